### rtl/srrl_pkg.sv
package srrl_pkg;

	localparam int SMP_W      = 16;
	localparam int SRC_W      = 12;
	localparam int TGT_W      = 16;
	localparam int OUT_W      = 17;
	localparam int PROD_W     = SRC_W + TGT_W;
	localparam int FRAC_W     = 3;
	localparam int QUO_W      = TGT_W + FRAC_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

	localparam logic [FRAC_W-1:0] ROUND_MASK     = 3'h7;
	localparam logic [FRAC_W-1:0] ROUND_THR      = 3'h3;
	localparam logic [SMP_W-1:0]  SIGN_BIT       = 16'h8000;
	localparam logic [SRC_W-1:0]  SOURCE_MAX_RST = 12'd4095;
	localparam logic [TGT_W-1:0]  TARGET_MAX_RST = 16'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_MAX = 2'd0,
		REG_TARGET_MAX = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic             neg;
		logic [SRC_W-1:0] rem;
		logic [QUO_W-1:0] dvd;
		logic [QUO_W-1:0] quo;
	} div_item_t;

endpackage

### rtl/srrl_front.sv
module srrl_front import srrl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [SMP_W-1:0] sample,
	input  logic [SRC_W-1:0] source_max,
	input  logic [TGT_W-1:0] target_max,
	output logic             out_valid,
	input  logic             out_ready,
	output div_item_t        out_item
);

	logic             valid_s1;
	logic             neg_s1;
	logic [SRC_W-1:0] mag_s1;
	logic             valid_s2;
	div_item_t        item_s2;
	logic             adv_s1;
	logic             adv_s2;
	logic [SMP_W:0]   sample_x;
	logic [SMP_W:0]   mag_full;
	logic [SRC_W-1:0] mag_clamp;
	logic [PROD_W-1:0] prod;

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_comb begin
		sample_x  = {sample[SMP_W-1], sample};
		mag_full  = ((sample & SIGN_BIT) != '0) ? (~sample_x + (SMP_W+1)'(1)) : sample_x;
		mag_clamp = (mag_full > {{(SMP_W+1-SRC_W){1'b0}}, source_max})
			? source_max : mag_full[SRC_W-1:0];
		prod      = PROD_W'(mag_s1) * PROD_W'(target_max);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			neg_s1 <= sample[SMP_W-1];
			mag_s1 <= mag_clamp;
		end
		if (adv_s2 && valid_s1) begin
			item_s2.neg <= neg_s1;
			item_s2.rem <= prod[PROD_W-1:TGT_W];
			item_s2.dvd <= {prod[TGT_W-1:0], {FRAC_W{1'b0}}};
			item_s2.quo <= '0;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

### rtl/srrl_div_stage.sv
module srrl_div_stage import srrl_pkg::*; #(
	parameter int TOP   = 18,
	parameter int STEPS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  div_item_t        in_item,
	input  logic [SRC_W-1:0] source_max,
	output logic             out_valid,
	input  logic             out_ready,
	output div_item_t        out_item
);

	logic      valid_s1;
	div_item_t item_s1;
	div_item_t nxt;
	logic      adv_s1;

	assign adv_s1   = !valid_s1 || out_ready;
	assign in_ready = adv_s1;

	always_comb begin
		logic [SRC_W:0] trial;
		nxt = in_item;
		for (int k = 0; k < STEPS; k++) begin
			trial = {nxt.rem, nxt.dvd[TOP-k]};
			if (trial >= {1'b0, source_max}) begin
				nxt.rem        = SRC_W'(trial - {1'b0, source_max});
				nxt.quo[TOP-k] = 1'b1;
			end else begin
				nxt.rem        = trial[SRC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			item_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

### rtl/srrl_round.sv
module srrl_round import srrl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  div_item_t        in_item,
	input  logic [SRC_W-1:0] source_max,
	output logic             scaled_valid,
	input  logic             scaled_stall,
	output logic [OUT_W-1:0] scaled
);

	logic             valid_s1;
	logic [OUT_W-1:0] scaled_s1;
	logic             adv_s1;
	logic             round_up;
	logic [OUT_W-1:0] mag;
	logic [OUT_W-1:0] res;

	assign adv_s1   = !valid_s1 || !scaled_stall;
	assign in_ready = adv_s1;

	always_comb begin
		round_up = (in_item.quo[FRAC_W-1:0] & ROUND_MASK) > ROUND_THR;
		mag      = {1'b0, in_item.quo[QUO_W-1:FRAC_W]} + OUT_W'(round_up);
		if (source_max == '0) begin
			res = '0;
		end else if (in_item.neg) begin
			res = ~mag + OUT_W'(1);
		end else begin
			res = mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			scaled_s1 <= res;
		end
	end

	assign scaled_valid = valid_s1;
	assign scaled       = scaled_s1;

endmodule

### rtl/signed_range_rescale_linear.sv
// Stages from sample to scaled valid: abs/clamp, multiply, five restoring
// divider stages of four quotient bits each (three in the last), round/negate.
// Throughput: one sample per cycle; each stage advances when its successor is
// empty or moving, so bubbles close up under output stall.
// Reset: arst_n clears all stage valid bits and loads source_max = 4095 and
// target_max = 255.
module signed_range_rescale_linear import srrl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  logic signed [SMP_W-1:0] sample,
	output logic                  scaled_valid,
	input  logic                  scaled_stall,
	output logic signed [OUT_W-1:0] scaled,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [SRC_W-1:0] source_max_q;
	logic [TGT_W-1:0] target_max_q;
	logic             front_ready;
	logic             div_valid [DIV_STAGES+1];
	logic             div_ready [DIV_STAGES+1];
	div_item_t        div_item  [DIV_STAGES+1];
	logic [OUT_W-1:0] scaled_raw;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_max_q <= SOURCE_MAX_RST;
			target_max_q <= TARGET_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SOURCE_MAX: source_max_q <= cfg_data[SRC_W-1:0];
				REG_TARGET_MAX: target_max_q <= cfg_data[TGT_W-1:0];
				default: ;
			endcase
		end
	end

	srrl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (sample_valid),
		.in_ready   (front_ready),
		.sample     (sample),
		.source_max (source_max_q),
		.target_max (target_max_q),
		.out_valid  (div_valid[0]),
		.out_ready  (div_ready[0]),
		.out_item   (div_item[0])
	);

	assign sample_stall = !front_ready;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		localparam int TOP   = QUO_W - 1 - g * DIV_STEPS;
		localparam int STEPS = (TOP + 1 < DIV_STEPS) ? TOP + 1 : DIV_STEPS;

		srrl_div_stage #(
			.TOP   (TOP),
			.STEPS (STEPS)
		) u_div (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_valid   (div_valid[g]),
			.in_ready   (div_ready[g]),
			.in_item    (div_item[g]),
			.source_max (source_max_q),
			.out_valid  (div_valid[g+1]),
			.out_ready  (div_ready[g+1]),
			.out_item   (div_item[g+1])
		);
	end

	srrl_round u_round (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (div_valid[DIV_STAGES]),
		.in_ready     (div_ready[DIV_STAGES]),
		.in_item      (div_item[DIV_STAGES]),
		.source_max   (source_max_q),
		.scaled_valid (scaled_valid),
		.scaled_stall (scaled_stall),
		.scaled       (scaled_raw)
	);

	assign scaled = $signed(scaled_raw);

endmodule

### rtl/srrl_checker.sv
module srrl_checker import srrl_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             sample_stall,
	input logic             scaled_valid,
	input logic             scaled_stall,
	input logic [OUT_W-1:0] scaled
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		scaled_valid && scaled_stall |=> scaled_valid)
		else $error("scaled_valid dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		scaled_valid && scaled_stall |=> $stable(scaled))
		else $error("scaled changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> scaled_valid && scaled_stall)
		else $error("sample stalled without a stalled output");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		scaled_valid |-> scaled != {1'b1, {(OUT_W-1){1'b0}}})
		else $error("scaled magnitude out of range");

endmodule

bind signed_range_rescale_linear srrl_checker u_srrl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_stall (sample_stall),
	.scaled_valid (scaled_valid),
	.scaled_stall (scaled_stall),
	.scaled       (scaled)
);
